// ===== hdl/hta_pkg.sv =====
// ----------------------------------------------------------------------------
// hta_pkg: shared constants and types
// conversion coefficients, ring geometry, reciprocal constants, fsm states
// ----------------------------------------------------------------------------
package hta_pkg;

    localparam int HUM_DEPTH  = 5;
    localparam int TEMP_DEPTH = 5;

    localparam int CODE_W = 16;
    localparam int VAL_W  = 17;
    localparam int COEF_W = 8;
    localparam int FRAC_W = 8;
    localparam int CONV_W = CODE_W + COEF_W;

    localparam int HUM_COEF    = 125;
    localparam int TEMP_COEF   = 176;
    localparam int HUM_OFFSET  = 1536;
    localparam int TEMP_OFFSET = 12032;
    localparam int HUM_MAX     = 25600;
    localparam int VAL_MAX     = 33023;

    localparam logic CH_HUM  = 1'b0;
    localparam logic CH_TEMP = 1'b1;

    localparam int MAX_DEPTH = (HUM_DEPTH > TEMP_DEPTH) ? HUM_DEPTH : TEMP_DEPTH;
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ENTRIES   = HUM_DEPTH + TEMP_DEPTH;
    localparam int ADDR_W    = $clog2(ENTRIES);

    // biased sum stays nonnegative: every entry is at least -TEMP_OFFSET
    localparam int SPAN    = VAL_MAX + TEMP_OFFSET;
    localparam int DIV_RAW = $clog2(MAX_DEPTH * SPAN + 1);
    localparam int DIV_W   = (DIV_RAW > VAL_W) ? DIV_RAW : VAL_W + 1;
    localparam int RECIP_W = DIV_W + 1;
    localparam int PROD_W  = DIV_W + RECIP_W;

    localparam logic [RECIP_W-1:0] HUM_RECIP  = RECIP_W'((2 ** DIV_W) / HUM_DEPTH);
    localparam logic [RECIP_W-1:0] TEMP_RECIP = RECIP_W'((2 ** DIV_W) / TEMP_DEPTH);
    localparam logic [DIV_W-1:0]   HUM_DIV    = DIV_W'(HUM_DEPTH);
    localparam logic [DIV_W-1:0]   TEMP_DIV   = DIV_W'(TEMP_DEPTH);
    localparam logic [DIV_W-1:0]   HUM_BIAS   = DIV_W'(HUM_DEPTH * TEMP_OFFSET);
    localparam logic [DIV_W-1:0]   TEMP_BIAS  = DIV_W'(TEMP_DEPTH * TEMP_OFFSET);
    localparam logic [IDX_W-1:0]   HUM_LAST   = IDX_W'(HUM_DEPTH - 1);
    localparam logic [IDX_W-1:0]   TEMP_LAST  = IDX_W'(TEMP_DEPTH - 1);
    localparam logic [ADDR_W-1:0]  HUM_BASE   = '0;
    localparam logic [ADDR_W-1:0]  TEMP_BASE  = ADDR_W'(HUM_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_WALK,
        S_DRAIN,
        S_MUL,
        S_FIX
    } state_t;

endpackage

// ===== hdl/hta_in_if.sv =====
// ----------------------------------------------------------------------------
// hta_in_if: sample channel
// valid/ready handshake carrying the channel select and the raw sensor code
// ----------------------------------------------------------------------------
interface hta_in_if;
    import hta_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [CODE_W-1:0] raw_code;

    modport source
    (
        output valid,
        output action,
        output raw_code,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  raw_code,
        output ready
    );

endinterface

// ===== hdl/hta_out_if.sv =====
// ----------------------------------------------------------------------------
// hta_out_if: result channel
// valid/ready handshake carrying the channel, converted reading and mean
// ----------------------------------------------------------------------------
interface hta_out_if;
    import hta_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    channel;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] average;

    modport source
    (
        output valid,
        output channel,
        output value,
        output average,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  channel,
        input  value,
        input  average,
        output ready
    );

endinterface

// ===== hdl/humidity_temp_convert_average.sv =====
// steps: S_CONV, S_WALK, S_DRAIN, S_MUL, then S_FIX loads the result once the
//   output register is free; a new sample is taken only back in S_IDLE, after
//   the walk over the channel's ring through the single memory read port
// a finished result waits in the output register while the next sample is taken
// reset: rst_n clears fsm, slot pointers and ring valid bits at once, no sweep;
//   an entry never written reads as zero
// ----------------------------------------------------------------------------
// humidity_temp_convert_average: sensor code conversion with moving average
// converts a raw code to fixed point, stores it in the channel's ring in a
// synchronous memory and returns the reading with the floored ring mean
// ----------------------------------------------------------------------------
module humidity_temp_convert_average
(
    input  logic clk,
    input  logic rst_n,
    hta_in_if.sink    sample,
    hta_out_if.source result
);
    import hta_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic                    chan_reg;
    logic [CODE_W-1:0]       code_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_valid_reg;

    logic [DIV_W-1:0]  sum_reg;
    logic [DIV_W-1:0]  sum_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    logic [IDX_W-1:0]   hum_slot_reg;
    logic [IDX_W-1:0]   hum_slot_next;
    logic [IDX_W-1:0]   temp_slot_reg;
    logic [IDX_W-1:0]   temp_slot_next;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_channel_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic signed [VAL_W-1:0] out_average_reg;
    logic signed [VAL_W-1:0] avg_next;
    logic                    out_load;

    logic signed [VAL_W-1:0] ring_mem [ENTRIES];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    ring_we;
    logic [ADDR_W-1:0]       ring_waddr;
    logic [ADDR_W-1:0]       rd_addr;

    // per-channel constants
    logic [IDX_W-1:0]   depth_last;
    logic [ADDR_W-1:0]  base;
    logic [RECIP_W-1:0] recip;
    logic [DIV_W-1:0]   depth_div;
    logic [DIV_W-1:0]   bias;
    logic [IDX_W-1:0]   slot_cur;

    // conversion datapath
    logic [COEF_W-1:0]       coef;
    logic [CONV_W-1:0]       conv_prod;
    logic signed [VAL_W:0]   conv_shift;
    logic signed [VAL_W:0]   conv_offset;
    logic signed [VAL_W:0]   conv_diff;

    // accumulate and divide datapath
    logic signed [VAL_W-1:0] entry;
    logic [DIV_W-1:0]        entry_ext;
    logic [DIV_W-1:0]        quot0;
    logic [DIV_W-1:0]        quot_back;
    logic [DIV_W-1:0]        rem;
    logic [DIV_W-1:0]        quot;
    logic [DIV_W-1:0]        avg_wide;

    assign sample.ready   = (state_reg == S_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.channel = out_channel_reg;
    assign result.value   = out_value_reg;
    assign result.average = out_average_reg;

    always_comb
    begin
        if (chan_reg == CH_TEMP)
        begin
            depth_last  = TEMP_LAST;
            base        = TEMP_BASE;
            recip       = TEMP_RECIP;
            depth_div   = TEMP_DIV;
            bias        = TEMP_BIAS;
            slot_cur    = temp_slot_reg;
            coef        = COEF_W'(TEMP_COEF);
            conv_offset = (VAL_W + 1)'(TEMP_OFFSET);
        end
        else
        begin
            depth_last  = HUM_LAST;
            base        = HUM_BASE;
            recip       = HUM_RECIP;
            depth_div   = HUM_DIV;
            bias        = HUM_BIAS;
            slot_cur    = hum_slot_reg;
            coef        = COEF_W'(HUM_COEF);
            conv_offset = (VAL_W + 1)'(HUM_OFFSET);
        end
    end

    // code conversion
    always_comb
    begin
        conv_prod  = CONV_W'(coef) * CONV_W'(code_reg);
        conv_shift = signed'({2'b00, conv_prod[CONV_W-1:FRAC_W]});
        conv_diff  = conv_shift - conv_offset;
        value_next = VAL_W'(conv_diff);
        if (chan_reg == CH_HUM)
        begin
            if (conv_diff < 0)
            begin
                value_next = '0;
            end
            else if (conv_diff > (VAL_W + 1)'(HUM_MAX))
            begin
                value_next = VAL_W'(HUM_MAX);
            end
        end
    end

    // entry of the walk, with the new reading forwarded into its slot
    always_comb
    begin
        if (rd_idx_reg == slot_cur)
        begin
            entry = value_reg;
        end
        else if (rd_valid_reg)
        begin
            entry = rd_data_reg;
        end
        else
        begin
            entry = '0;
        end
        entry_ext = {{(DIV_W - VAL_W){entry[VAL_W-1]}}, entry};
    end

    // floored mean by reciprocal multiply and one correction step
    always_comb
    begin
        quot0     = prod_reg[DIV_W +: DIV_W];
        quot_back = quot0 * depth_div;
        rem       = sum_reg - quot_back;
        quot      = (rem >= depth_div) ? quot0 + DIV_W'(1) : quot0;
        avg_wide  = quot - DIV_W'(TEMP_OFFSET);
        avg_next  = VAL_W'(avg_wide);
    end

    assign rd_addr    = base + ADDR_W'(cnt_reg);
    assign ring_waddr = base + ADDR_W'(slot_cur);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        hum_slot_next  = hum_slot_reg;
        temp_slot_next = temp_slot_reg;
        valid_next     = valid_reg;
        ring_we        = 1'b0;
        out_load       = 1'b0;

        if (rd_pend_reg)
        begin
            sum_next = sum_reg + entry_ext;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cnt_next   = '0;
                sum_next   = bias;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                rd_pend_next = 1'b1;
                if (cnt_reg == depth_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ring_we                = 1'b1;
                valid_next[ring_waddr] = 1'b1;
                prod_next              = PROD_W'(sum_reg) * PROD_W'(recip);
                if (chan_reg == CH_TEMP)
                begin
                    temp_slot_next = (temp_slot_reg == TEMP_LAST) ? '0
                                                                  : temp_slot_reg + IDX_W'(1);
                end
                else
                begin
                    hum_slot_next = (hum_slot_reg == HUM_LAST) ? '0
                                                               : hum_slot_reg + IDX_W'(1);
                end
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            hum_slot_reg  <= '0;
            temp_slot_reg <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= cnt_reg;
            rd_valid_reg  <= valid_reg[rd_addr];
            hum_slot_reg  <= hum_slot_next;
            temp_slot_reg <= temp_slot_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            chan_reg <= sample.action;
            code_reg <= sample.raw_code;
        end
        if (state_reg == S_CONV)
        begin
            value_reg <= value_next;
        end
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        if (out_load)
        begin
            out_channel_reg <= chan_reg;
            out_value_reg   <= value_reg;
            out_average_reg <= avg_next;
        end
    end

    // ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= value_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> state_reg == S_CONV)
        else $error("accepted transaction did not start conversion");

    a_write_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> !rd_pend_reg && $past(state_reg) == S_DRAIN)
        else $error("ring write overlaps the walk");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        hum_slot_reg <= HUM_LAST && temp_slot_reg <= TEMP_LAST)
        else $error("slot pointer beyond ring depth");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_channel_reg == CH_HUM
        |-> out_value_reg >= 0 && out_value_reg <= HUM_MAX
            && out_average_reg >= 0 && out_average_reg <= HUM_MAX)
        else $error("humidity result out of range");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIX && (!out_valid_reg || result.ready)
        |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished result not presented");

endmodule

// ===== dv/humidity_temp_convert_average_tb.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_convert_average_tb: conversion and moving average check
// drives humidity and temperature codes through the sample channel with
// random idling and stalls, predicts each reading and ring mean, and
// compares every result transaction in order
// ----------------------------------------------------------------------------
module humidity_temp_convert_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hta_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int RANDOM_ITEMS  = 1530;
    localparam int QUIET_FROM    = 700;
    localparam int QUIET_TO      = 1000;
    localparam int HOLD_AT       = 350;
    localparam int HOLD_CYCLES   = 240;
    localparam int IDLE_PERCENT  = 26;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic              action;
        logic [CODE_W-1:0] raw_code;
    } sample_t;

    typedef struct {
        logic                    channel;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] average;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n;

    hta_in_if  sample_ch();
    hta_out_if result_ch();

    humidity_temp_convert_average uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    sample_t  samples_pending[$];
    reading_t readings_due[$];

    logic        [14:0]      hum_hist[HUM_DEPTH]  = '{default: '0};
    logic signed [VAL_W-1:0] temp_hist[TEMP_DEPTH] = '{default: '0};
    logic        [IDX_W-1:0] hum_next  = '0;
    logic        [IDX_W-1:0] temp_next = '0;

    int errors      = 0;
    int sent_count  = 0;
    int recv_count  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    always #6 clk = ~clk;

    function automatic int floored_div(input int sum, input int depth);
        if (sum >= 0)
            return sum / depth;
        return -((-sum + depth - 1) / depth);
    endfunction

    function automatic reading_t convert_and_average(input logic act,
                                                     input logic [CODE_W-1:0] code);
        int       scaled;
        int       sum;
        reading_t r;
        sum = 0;
        if (act == CH_HUM)
        begin
            scaled = ((HUM_COEF * int'(code)) >>> FRAC_W) - HUM_OFFSET;
            if (scaled < 0)
                scaled = 0;
            else if (scaled > HUM_MAX)
                scaled = HUM_MAX;
            if (hum_next >= HUM_DEPTH)
                hum_next = '0;
            hum_hist[hum_next] = scaled[14:0];
            hum_next = (hum_next + 1 >= HUM_DEPTH) ? '0 : hum_next + 1'b1;
            for (int k = 0; k < HUM_DEPTH; k++)
                sum += int'(hum_hist[k]);
            r.average = VAL_W'(floored_div(sum, HUM_DEPTH));
        end
        else
        begin
            scaled = ((TEMP_COEF * int'(code)) >>> FRAC_W) - TEMP_OFFSET;
            if (temp_next >= TEMP_DEPTH)
                temp_next = '0;
            temp_hist[temp_next] = VAL_W'(scaled);
            temp_next = (temp_next + 1 >= TEMP_DEPTH) ? '0 : temp_next + 1'b1;
            for (int k = 0; k < TEMP_DEPTH; k++)
                sum += int'(temp_hist[k]);
            r.average = VAL_W'(floored_div(sum, TEMP_DEPTH));
        end
        r.channel = act;
        r.value   = VAL_W'(scaled);
        return r;
    endfunction

    task automatic queue_sample(input logic act, input logic [CODE_W-1:0] code);
        sample_t s;
        s.action   = act;
        s.raw_code = code;
        samples_pending.push_back(s);
    endtask

    // wait until every queued sample is taken and every reading has come back
    task automatic wait_drained();
        while (samples_pending.size() != 0 || sample_ch.valid)
            @(posedge clk);
        while (readings_due.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid    <= 1'b0;
            sample_ch.action   <= 1'b0;
            sample_ch.raw_code <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                readings_due.push_back(convert_and_average(sample_ch.action,
                                                           sample_ch.raw_code));
                sent_count++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (samples_pending.size() != 0 &&
                    ((sent_count >= QUIET_FROM && sent_count < QUIET_TO) ||
                     $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    sample_ch.valid    <= 1'b1;
                    sample_ch.action   <= samples_pending[0].action;
                    sample_ch.raw_code <= samples_pending[0].raw_code;
                    void'(samples_pending.pop_front());
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual ch %0d val %0d avg %0d",
                             $time, result_ch.channel, result_ch.value, result_ch.average);
                    errors++;
                end
                else
                begin
                    if (result_ch.channel !== readings_due[0].channel)
                    begin
                        $display("%0t channel mismatch: expected %0d actual %0d",
                                 $time, readings_due[0].channel, result_ch.channel);
                        errors++;
                    end
                    if (result_ch.value !== readings_due[0].value)
                    begin
                        $display("%0t value mismatch: expected %0d actual %0d",
                                 $time, readings_due[0].value, result_ch.value);
                        errors++;
                    end
                    if (result_ch.average !== readings_due[0].average)
                    begin
                        $display("%0t average mismatch: expected %0d actual %0d",
                                 $time, readings_due[0].average, result_ch.average);
                        errors++;
                    end
                    void'(readings_due.pop_front());
                end
                recv_count++;
            end
            // long hold-off so the block backs up and stalls its input
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!hold_done && recv_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else if (recv_count >= QUIET_FROM && recv_count < QUIET_TO)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int                mode;
        logic              act;
        logic [CODE_W-1:0] code;

        rst_n = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, clamp edges, zero crossings, negative sums, ring wrap
        queue_sample(CH_HUM, 16'd0);
        queue_sample(CH_TEMP, 16'd0);
        queue_sample(CH_TEMP, 16'd17501);
        queue_sample(CH_HUM, 16'd3145);
        queue_sample(CH_HUM, 16'd3146);
        queue_sample(CH_TEMP, 16'd17502);
        queue_sample(CH_HUM, 16'd55574);
        queue_sample(CH_HUM, 16'd55575);
        queue_sample(CH_HUM, 16'd65535);
        queue_sample(CH_TEMP, 16'd65535);
        queue_sample(CH_TEMP, 16'd0);
        queue_sample(CH_TEMP, 16'd0);
        queue_sample(CH_TEMP, 16'd1);
        queue_sample(CH_TEMP, 16'd0);
        queue_sample(CH_HUM, 16'd65535);
        queue_sample(CH_HUM, 16'd65535);
        queue_sample(CH_HUM, 16'd32768);
        queue_sample(CH_TEMP, 16'd32768);
        queue_sample(CH_TEMP, 16'd65535);
        queue_sample(CH_TEMP, 16'd65535);
        queue_sample(CH_HUM, 16'd1);
        queue_sample(CH_TEMP, 16'd21845);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            act  = 1'($urandom_range(0, 1));
            mode = $urandom_range(0, 9);
            case (mode)
                0: code = CODE_W'($urandom_range(0, 63));
                1: code = CODE_W'($urandom_range(65472, 65535));
                2: code = CODE_W'($urandom_range(3100, 3200));
                3: code = CODE_W'($urandom_range(55500, 55650));
                4: code = CODE_W'($urandom_range(17450, 17550));
                default: code = CODE_W'($urandom_range(0, 65535));
            endcase
            queue_sample(act, code);
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
